// ===== hdl/plcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plcc_pkg
// Shared widths, codes and defaults for the pressure limit curve classifier.
// ---------------------------------------------------------------------------
package plcc_pkg;

  localparam int PLCC_CURVE_POINTS = 5;

  localparam int SPD_W  = 16;
  localparam int PRS_W  = 16;
  localparam int MIN_W  = 13;
  localparam int DB_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STAT_W = 3;

  localparam int DIF_W  = 17;
  localparam int SLP_W  = 27;
  localparam int MUL_W  = 44;
  localparam int DVD_W  = 42;
  localparam int DEN_W  = 16;
  localparam int LIM_W  = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEADBAND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_DEADBAND  = 2'd3;

  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  localparam logic CURVE_MAX = 1'b0;
  localparam logic CURVE_MAP = 1'b1;

  localparam logic [STAT_W-1:0] ST_BELOW_MAP = 3'd0;
  localparam logic [STAT_W-1:0] ST_IN_MAP    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ABOVE_MAP = 3'd2;
  localparam logic [STAT_W-1:0] ST_WARNING   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EXCEEDED  = 3'd4;

  localparam logic signed [DIF_W-1:0] SLOPE_SCALE = 17'sd1000;
  localparam logic [DEN_W-1:0] OFF_SCALE  = 16'd1000;
  localparam logic [DEN_W-1:0] BASE_SCALE = 16'd100;
  localparam logic [4:0] RPM_SCALE = 5'd10;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SEARCH  = 9'b000000010,
    S_FETCH_HI = 9'b000000100,
    S_FETCH_LO = 9'b000001000,
    S_MUL     = 9'b000010000,
    S_DLOAD   = 9'b000100000,
    S_DIV     = 9'b001000000,
    S_LIM     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    PH_SLOPE = 2'd0,
    PH_OFF   = 2'd1,
    PH_BASE  = 2'd2
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/pressure_limit_curve_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pressure_limit_curve_classifier
// Classifies a manifold pressure sample against a maximum and a map limit
// curve, each a piecewise-linear table of speed/pressure points.
// ---------------------------------------------------------------------------
// Load items write one curve point in the cycle they are accepted and give no
// result. A check item searches the maximum curve for its speed segment (one
// point per cycle), then interpolates the limit with one shared multiplier and
// one shared restoring divider (42 quotient bits, one per cycle). A curve
// evaluation takes up to two multiply/divide rounds; a check that needs the map
// curve too evaluates both curves, and a check that is disabled or not above the
// minimum speed goes straight to its status. The input is stalled while a check
// is at work; a finished status waits in an output register.
// ---------------------------------------------------------------------------
module pressure_limit_curve_classifier
  import plcc_pkg::*;
#(
  parameter int CURVE_POINTS = PLCC_CURVE_POINTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  kind,
  input  wire logic [SPD_W-1:0]      engine_speed,
  input  wire logic [PRS_W-1:0]      manifold_pressure,
  input  wire logic                  curve_select,
  input  wire logic [2:0]            point_index,
  input  wire logic [SPD_W-1:0]      point_speed,
  input  wire logic [PRS_W-1:0]      point_pressure,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STAT_W-1:0]          status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(CURVE_POINTS);
  localparam int CW = $clog2(CURVE_POINTS + 1);
  localparam int DCW = $clog2(DVD_W + 1);

  state_t state;
  phase_t phase;

  logic [SPD_W-1:0] max_spd [CURVE_POINTS];
  logic [PRS_W-1:0] max_prs [CURVE_POINTS];
  logic [SPD_W-1:0] map_spd [CURVE_POINTS];
  logic [PRS_W-1:0] map_prs [CURVE_POINTS];

  logic             check_en;
  logic [MIN_W-1:0] min_speed;
  logic [DB_W-1:0]  max_db;
  logic [DB_W-1:0]  map_db;

  logic [SPD_W-1:0] speed_r;
  logic [PRS_W-1:0] pressure_r;
  logic             cur;
  logic [CW-1:0]    seg;
  logic             end_r;
  logic [SPD_W-1:0] s_hi;
  logic [SPD_W-1:0] s_lo;
  logic [PRS_W-1:0] p_hi;
  logic [PRS_W-1:0] p_lo;
  logic signed [SLP_W-1:0] slope;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [LIM_W-1:0] lim;
  logic [STAT_W-1:0] result;

  logic [DVD_W-1:0] div_q;
  logic [DEN_W-1:0] div_r;
  logic [DEN_W-1:0] div_den;
  logic             div_neg;
  logic [DCW-1:0]   div_cnt;

  // curve read port
  logic             seg_in;
  logic [IW-1:0]    rd_idx;
  logic [SPD_W-1:0] rd_spd;
  logic [PRS_W-1:0] rd_prs;
  logic [CW-1:0]    seg_dec;
  logic [IW-1:0]    ld_idx;

  assign seg_in  = seg < CW'(CURVE_POINTS);
  assign seg_dec = seg - CW'(1);
  assign ld_idx  = IW'(point_index);

  always_comb begin
    rd_idx = '0;
    if (state == S_FETCH_LO) begin
      rd_idx = seg_dec[IW-1:0];
    end else if (seg_in) begin
      rd_idx = seg[IW-1:0];
    end
  end

  assign rd_spd = (cur == CURVE_MAP) ? map_spd[rd_idx] : max_spd[rd_idx];
  assign rd_prs = (cur == CURVE_MAP) ? map_prs[rd_idx] : max_prs[rd_idx];

  // segment arithmetic
  logic signed [DIF_W-1:0] w;
  logic signed [DIF_W-1:0] d;
  logic signed [DIF_W-1:0] off;
  logic [DIF_W-1:0]        w_mag;
  assign w = $signed({1'b0, s_hi}) - $signed({1'b0, s_lo});
  assign d = $signed({1'b0, p_hi}) - $signed({1'b0, p_lo});
  assign off = $signed({1'b0, speed_r}) - $signed({1'b0, s_lo});
  assign w_mag = w[DIF_W-1] ? DIF_W'(-w) : DIF_W'(w);

  // shared multiplier
  logic signed [SLP_W-1:0] mul_a;
  logic signed [DIF_W-1:0] mul_b;
  logic signed [MUL_W-1:0] mul_prod;
  always_comb begin
    if (phase == PH_SLOPE) begin
      mul_a = SLP_W'(d);
      mul_b = SLOPE_SCALE;
    end else begin
      mul_a = slope;
      mul_b = off;
    end
  end
  assign mul_prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  logic [MUL_W-1:0] mul_mag;
  assign mul_mag = mul_p[MUL_W-1] ? MUL_W'(-mul_p) : MUL_W'(mul_p);

  // shared divider step
  logic [DEN_W:0] r_sh;
  logic           r_ge;
  logic [DEN_W:0] r_sub;
  assign r_sh  = {div_r, div_q[DVD_W-1]};
  assign r_ge  = r_sh >= {1'b0, div_den};
  assign r_sub = r_sh - {1'b0, div_den};

  logic signed [DVD_W:0] q_s;
  assign q_s = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // classification
  logic signed [LIM_W-1:0] pr_x;
  logic signed [LIM_W-1:0] mdb_x;
  logic signed [LIM_W-1:0] pdb_x;
  logic signed [LIM_W-1:0] plo_x;
  logic signed [LIM_W-1:0] phi_x;
  assign pr_x  = $signed(LIM_W'(pressure_r));
  assign mdb_x = $signed(LIM_W'(max_db));
  assign pdb_x = $signed(LIM_W'(map_db));
  assign plo_x = $signed(LIM_W'(p_lo));
  assign phi_x = $signed(LIM_W'(rd_prs));

  logic [SPD_W:0] min_x10;
  assign min_x10 = (SPD_W+1)'(min_speed) * (SPD_W+1)'(RPM_SCALE);

  logic in_xfer;
  logic out_free;
  assign in_stall  = state != S_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_en  <= 1'b0;
      min_speed <= '0;
      max_db    <= '0;
      map_db    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHECK_ENABLED: check_en  <= cfg_data[0];
        CFG_MIN_SPEED:     min_speed <= cfg_data[MIN_W-1:0];
        CFG_MAX_DEADBAND:  max_db    <= cfg_data[DB_W-1:0];
        CFG_MAP_DEADBAND:  map_db    <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CURVE_POINTS; i++) begin
        max_spd[i] <= '0;
        max_prs[i] <= '0;
        map_spd[i] <= '0;
        map_prs[i] <= '0;
      end
    end else if (in_xfer && kind == KIND_LOAD
                 && 32'(point_index) < 32'(CURVE_POINTS)) begin
      if (curve_select == CURVE_MAP) begin
        map_spd[ld_idx] <= point_speed;
        map_prs[ld_idx] <= point_pressure;
      end else begin
        max_spd[ld_idx] <= point_speed;
        max_prs[ld_idx] <= point_pressure;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_SLOPE;
      cur       <= CURVE_MAX;
      seg       <= '0;
      div_cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && kind == KIND_CHECK) begin
            speed_r    <= engine_speed;
            pressure_r <= manifold_pressure;
            cur        <= CURVE_MAX;
            seg        <= '0;
            if (check_en && (SPD_W+1)'(engine_speed) > min_x10) begin
              state <= S_SEARCH;
            end else begin
              result <= ST_BELOW_MAP;
              state  <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          if (!seg_in || rd_spd == '0 || speed_r <= rd_spd) begin
            state <= S_FETCH_HI;
          end else begin
            seg <= seg + CW'(1);
          end
        end
        S_FETCH_HI: begin
          s_hi  <= rd_spd;
          p_hi  <= rd_prs;
          end_r <= !seg_in || rd_spd == '0;
          if (seg == '0) begin
            if (!seg_in || rd_spd == '0) begin
              div_q   <= DVD_W'(speed_r);
              div_r   <= '0;
              div_den <= BASE_SCALE;
              div_neg <= 1'b0;
              div_cnt <= DCW'(DVD_W);
              phase   <= PH_BASE;
              state   <= S_DIV;
            end else begin
              lim   <= phi_x;
              state <= S_LIM;
            end
          end else begin
            state <= S_FETCH_LO;
          end
        end
        S_FETCH_LO: begin
          s_lo <= rd_spd;
          p_lo <= rd_prs;
          if (end_r) begin
            lim   <= phi_x;
            state <= S_LIM;
          end else begin
            phase <= PH_SLOPE;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (phase == PH_SLOPE && w == '0) begin
            slope <= '0;
            phase <= PH_OFF;
          end else begin
            mul_p <= mul_prod;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          div_q   <= mul_mag[DVD_W-1:0];
          div_r   <= '0;
          div_cnt <= DCW'(DVD_W);
          if (phase == PH_SLOPE) begin
            div_den <= w_mag[DEN_W-1:0];
            div_neg <= mul_p[MUL_W-1] ^ w[DIF_W-1];
          end else begin
            div_den <= OFF_SCALE;
            div_neg <= mul_p[MUL_W-1];
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            case (phase)
              PH_SLOPE: begin
                slope <= q_s[SLP_W-1:0];
                phase <= PH_OFF;
                state <= S_MUL;
              end
              PH_OFF: begin
                lim   <= plo_x + $signed(q_s[LIM_W-1:0]);
                state <= S_LIM;
              end
              default: begin
                lim   <= $signed(q_s[LIM_W-1:0]);
                state <= S_LIM;
              end
            endcase
          end else begin
            div_r   <= r_ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
            div_q   <= {div_q[DVD_W-2:0], r_ge};
            div_cnt <= div_cnt - DCW'(1);
          end
        end
        S_LIM: begin
          if (cur == CURVE_MAX) begin
            if (pr_x > lim) begin
              result <= ST_EXCEEDED;
              state  <= S_DONE;
            end else if (pr_x > lim - mdb_x) begin
              result <= ST_WARNING;
              state  <= S_DONE;
            end else begin
              cur   <= CURVE_MAP;
              state <= S_FETCH_HI;
            end
          end else begin
            if (pr_x > lim + pdb_x) begin
              result <= ST_ABOVE_MAP;
            end else if (pr_x > lim - pdb_x) begin
              result <= ST_IN_MAP;
            end else begin
              result <= ST_BELOW_MAP;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            status    <= result;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
